FILE: rtl/sate_pkg.sv
`timescale 1ns / 1ps

package sate_pkg;

  // Sprite entry field widths and position constants
  localparam int unsigned PosBits    = 9;
  localparam int unsigned CoordBits  = 10;
  localparam int unsigned TileBits   = 16;
  localparam int unsigned ColourBits = 5;
  localparam int unsigned MultiBits  = 3;

  localparam logic [PosBits-1:0]     XWrapStart = 9'd320;
  localparam logic signed [10:0]     XMirror    = 11'sd304;
  localparam logic signed [10:0]     YMirror    = 11'sd240;
  localparam logic signed [10:0]     XLimit     = 11'sd320;
  localparam logic [CoordBits-1:0]   TileStep   = 10'd16;

  typedef enum logic {
    StIdle,
    StEmit
  } sate_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } sate_cmd_t;

  typedef struct packed {
    logic drop;
    logic last;
  } sate_status_t;

endpackage

FILE: rtl/sate_ctrl.sv
`timescale 1ns / 1ps

module sate_ctrl
  import sate_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  sate_status_t status_i,
  output sate_cmd_t    cmd_o
);

  sate_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        // dropped sprites never leave idle
        if (in_valid_i && !status_i.drop) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!out_stall_i && status_i.last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i && !status_i.drop;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        cmd_o.step  = !out_stall_i && !status_i.last;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/sate_datapath.sv
`timescale 1ns / 1ps

module sate_datapath
  import sate_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic [15:0]            attr_y_word_i,
  input  logic [15:0]            tile_code_word_i,
  input  logic [15:0]            attr_x_word_i,
  input  logic                   odd_frame_i,
  input  sate_cmd_t              cmd_i,
  output sate_status_t           status_o,
  output logic [TileBits-1:0]    tile_number_o,
  output logic [ColourBits-1:0]  palette_colour_o,
  output logic                   mirror_x_o,
  output logic                   mirror_y_o,
  output logic signed [9:0]      screen_x_o,
  output logic signed [9:0]      screen_y_o,
  output logic                   last_tile_o
);

  logic                  flip_scr_q;

  logic [PosBits-1:0]    x_raw, y_raw;
  logic signed [9:0]     x_dec, y_dec;
  logic signed [10:0]    x_mir, y_mir;
  logic [CoordBits-1:0]  x_sel, y_sel, row_start, multi_px;
  logic [MultiBits-1:0]  multi;
  logic [TileBits-1:0]   base;

  logic [TileBits-1:0]   base_q;
  logic [ColourBits-1:0] colour_q;
  logic                  fx_q, fy_q, fy_entry_q, flip_q;
  logic [CoordBits-1:0]  x_q, row_q, row_d;
  logic [MultiBits-1:0]  multi_q, m_q, tile_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_scr_q <= 1'b0;
    end else if (cfg_we_i) begin
      flip_scr_q <= cfg_wdata_i;
    end
  end

  // Position decode
  assign x_raw = attr_x_word_i[PosBits-1:0];
  assign y_raw = attr_y_word_i[PosBits-1:0];
  // values at or past the wrap point read as negative (minus 512)
  assign x_dec = (x_raw >= XWrapStart) ? {1'b1, x_raw} : {1'b0, x_raw};
  assign y_dec = {y_raw[PosBits-1], y_raw};
  assign x_mir = XMirror - {x_dec[9], x_dec};
  assign y_mir = YMirror - {y_dec[9], y_dec};

  assign x_sel = flip_scr_q ? x_dec : x_mir[9:0];
  assign y_sel = flip_scr_q ? y_dec : y_mir[9:0];

  always_comb begin
    unique case (attr_y_word_i[10:9])
      2'd0:    multi = 3'd0;
      2'd1:    multi = 3'd1;
      2'd2:    multi = 3'd3;
      default: multi = 3'd7;
    endcase
  end

  assign base      = tile_code_word_i & ~{13'd0, multi};
  assign multi_px  = {3'd0, multi, 4'd0};
  // first command is the farthest tile from the anchor row
  assign row_start = flip_scr_q ? (y_sel + multi_px) : (y_sel - multi_px);

  assign status_o.drop = (tile_code_word_i == '0)
                      || (attr_y_word_i[12] && odd_frame_i)
                      || (x_mir > XLimit);
  assign status_o.last = (m_q == '0);

  // walk back toward the anchor row
  assign row_d = flip_q ? (row_q - TileStep) : (row_q + TileStep);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q     <= base;
      colour_q   <= attr_x_word_i[13:9];
      fx_q       <= attr_y_word_i[13] ^ flip_scr_q;
      fy_q       <= attr_y_word_i[14] ^ flip_scr_q;
      fy_entry_q <= attr_y_word_i[14];
      flip_q     <= flip_scr_q;
      x_q        <= x_sel;
      row_q      <= row_start;
      multi_q    <= multi;
      m_q        <= multi;
    end else if (cmd_i.step) begin
      row_q <= row_d;
      m_q   <= m_q - 3'd1;
    end
  end

  // low bits of base are clear, so OR stands for the add
  assign tile_off = fy_entry_q ? m_q : (multi_q - m_q);

  assign tile_number_o    = base_q | {13'd0, tile_off};
  assign palette_colour_o = colour_q;
  assign mirror_x_o       = fx_q;
  assign mirror_y_o       = fy_q;
  assign screen_x_o       = x_q;
  assign screen_y_o       = row_q;
  assign last_tile_o      = status_o.last;

endmodule

FILE: rtl/sprite_attribute_tile_emitter_unit.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake               | Word
// ---------+-----------+-------------------------+----------------------------------------
// in       | input     | in_valid_i/in_stall_o   | attr_y_word, tile_code_word, attr_x_word,
//          |           |                         | odd_frame
// out      | output    | out_valid_o/out_stall_i | tile command fields, last_tile
// cfg      | input     | cfg_valid_i/cfg_ready_o | screen_flipped (cfg_wdata_i)
//
// A sprite of h tiles (1, 2, 4 or 8) is decoded when the entry is taken, then the tile
// counter gives one command per cycle while the output does not stall. A dropped entry
// is taken and gives no command. A stall on the output holds the command.
// Reset clears the controller to idle and screen_flipped to 0.

module sprite_attribute_tile_emitter_unit
  import sate_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [15:0]       attr_y_word_i,
  input  logic [15:0]       tile_code_word_i,
  input  logic [15:0]       attr_x_word_i,
  input  logic              odd_frame_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       tile_number_o,
  output logic [4:0]        palette_colour_o,
  output logic              mirror_x_o,
  output logic              mirror_y_o,
  output logic signed [9:0] screen_x_o,
  output logic signed [9:0] screen_y_o,
  output logic              last_tile_o
);

  sate_cmd_t    cmd;
  sate_status_t status;

  assign cfg_ready_o = 1'b1;

  sate_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sate_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_wdata_i      (cfg_wdata_i),
    .attr_y_word_i    (attr_y_word_i),
    .tile_code_word_i (tile_code_word_i),
    .attr_x_word_i    (attr_x_word_i),
    .odd_frame_i      (odd_frame_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .tile_number_o    (tile_number_o),
    .palette_colour_o (palette_colour_o),
    .mirror_x_o       (mirror_x_o),
    .mirror_y_o       (mirror_y_o),
    .screen_x_o       (screen_x_o),
    .screen_y_o       (screen_y_o),
    .last_tile_o      (last_tile_o)
  );

endmodule

FILE: test/tb_sprite_attribute_tile_emitter_unit.sv
`timescale 1ns / 1ps

module tb_sprite_attribute_tile_emitter_unit;

  typedef struct packed {
    logic [15:0] attr_y;
    logic [15:0] tile_code;
    logic [15:0] attr_x;
    logic        odd;
  } sprite_t;

  typedef struct packed {
    logic [15:0]       tile;
    logic [4:0]        colour;
    logic              mir_x;
    logic              mir_y;
    logic signed [9:0] col;
    logic signed [9:0] row;
    logic              last;
  } tile_cmd_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_wdata_i = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [15:0]       attr_y_word_i = '0;
  logic [15:0]       tile_code_word_i = '0;
  logic [15:0]       attr_x_word_i = '0;
  logic              odd_frame_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [15:0]       tile_number_o;
  logic [4:0]        palette_colour_o;
  logic              mirror_x_o;
  logic              mirror_y_o;
  logic signed [9:0] screen_x_o;
  logic signed [9:0] screen_y_o;
  logic              last_tile_o;

  sprite_t   sprite_q[$];
  tile_cmd_t tile_cmds_q[$];
  sprite_t   next_sprite;
  tile_cmd_t want_cmd;
  bit        flip_setting = 1'b0;
  bit        in_took = 1'b0;
  bit        long_hold = 1'b0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        mismatches = 0;

  sprite_attribute_tile_emitter_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .attr_y_word_i    (attr_y_word_i),
    .tile_code_word_i (tile_code_word_i),
    .attr_x_word_i    (attr_x_word_i),
    .odd_frame_i      (odd_frame_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .tile_number_o    (tile_number_o),
    .palette_colour_o (palette_colour_o),
    .mirror_x_o       (mirror_x_o),
    .mirror_y_o       (mirror_y_o),
    .screen_x_o       (screen_x_o),
    .screen_y_o       (screen_y_o),
    .last_tile_o      (last_tile_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(string line);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] mismatch: %s", $realtime, line);
    end
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  // Empty slot, flash on odd frame, and x off the right side draw nothing.
  function automatic bit sprite_drawn(sprite_t s);
    int x;
    x = s.attr_x[8:0];
    if (x >= 320) x -= 512;
    return (s.tile_code != 16'd0) && !(s.attr_y[12] && s.odd) && (304 - x <= 320);
  endfunction

  task automatic predict_tiles(sprite_t s);
    int        x;
    int        y;
    int        dy;
    int        m;
    int        multi;
    logic [15:0] base;
    tile_cmd_t cmd;
    if (!sprite_drawn(s)) return;
    multi = (1 << s.attr_y[10:9]) - 1;
    x = s.attr_x[8:0];
    y = s.attr_y[8:0];
    if (x >= 320) x -= 512;
    if (y >= 256) y -= 512;
    x = 304 - x;
    y = 240 - y;
    base = s.tile_code & ~16'(multi);
    cmd.colour = s.attr_x[13:9];
    cmd.mir_x = s.attr_y[13];
    cmd.mir_y = s.attr_y[14];
    dy = -16;
    if (flip_setting) begin
      x = 304 - x;
      y = 240 - y;
      cmd.mir_x = !cmd.mir_x;
      cmd.mir_y = !cmd.mir_y;
      dy = 16;
    end
    cmd.col = 10'(x);
    // Flip y on the entry itself reverses the code order down the column.
    for (m = multi; m >= 0; m--) begin
      cmd.tile = s.attr_y[14] ? base + 16'(m) : base + 16'(multi - m);
      cmd.row = 10'(y + dy * m);
      cmd.last = (m == 0);
      tile_cmds_q.push_back(cmd);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (sprite_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sprite = sprite_q.pop_front();
        in_valid_i       <= 1'b1;
        attr_y_word_i    <= next_sprite.attr_y;
        tile_code_word_i <= next_sprite.tile_code;
        attr_x_word_i    <= next_sprite.attr_x;
        odd_frame_i      <= next_sprite.odd;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (long_hold) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (in_took) begin
      predict_tiles('{attr_y_word_i, tile_code_word_i, attr_x_word_i, odd_frame_i});
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tile_cmds_q.size() == 0) begin
        report_mismatch($sformatf("unexpected command, tile 0x%0h", tile_number_o));
      end else begin
        want_cmd = tile_cmds_q.pop_front();
        check_field("tile_number", tile_number_o, want_cmd.tile);
        check_field("palette_colour", 16'(palette_colour_o), 16'(want_cmd.colour));
        check_field("mirror_x", 16'(mirror_x_o), 16'(want_cmd.mir_x));
        check_field("mirror_y", 16'(mirror_y_o), 16'(want_cmd.mir_y));
        check_field("screen_x", 16'(unsigned'(screen_x_o)), 16'(unsigned'(want_cmd.col)));
        check_field("screen_y", 16'(unsigned'(screen_y_o)), 16'(unsigned'(want_cmd.row)));
        check_field("last_tile", 16'(last_tile_o), 16'(want_cmd.last));
      end
    end
  end

  task automatic add_sprite(logic [15:0] ay, logic [15:0] code, logic [15:0] ax, logic odd);
    sprite_q.push_back('{ay, code, ax, odd});
  endtask

  // Wait until every word is taken and every command has come out.
  task automatic drain();
    do @(negedge clk_i);
    while (sprite_q.size() != 0 || in_valid_i || tile_cmds_q.size() != 0);
    // a dropped entry may still be in decode
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_flip(bit value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    flip_setting = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic sprite_t random_sprite();
    sprite_t s;
    s.attr_y = 16'($urandom);
    s.tile_code = 16'($urandom);
    s.attr_x = 16'($urandom);
    s.odd = 1'($urandom);
    if ($urandom_range(99) < 80) begin
      // well-formed entry with random content
      if (s.tile_code == 16'd0) s.tile_code = 16'($urandom_range(16'hffff, 1));
      if ($urandom_range(99) < 85) s.attr_x[8:0] = 9'($urandom_range(319, 0));
      else s.attr_x[8:0] = 9'($urandom_range(511, 496));
      if (s.attr_y[12] && $urandom_range(3) != 0) s.odd = 1'b0;
    end else begin
      case ($urandom_range(2))
        0: s.tile_code = 16'd0;
        1: begin
          s.attr_y[12] = 1'b1;
          s.odd = 1'b1;
        end
        default: s.attr_x[8:0] = 9'($urandom_range(495, 320));
      endcase
    end
    return s;
  endfunction

  task automatic queue_random(int count);
    int queued;
    sprite_t s;
    queued = 0;
    while (queued < count) begin
      s = random_sprite();
      sprite_q.push_back(s);
      queued++;
    end
  endtask

  task automatic run_phase(bit flip, int idle_pct, int hold_pct, int count, bit squeeze);
    drain();
    write_flip(flip);
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    if (squeeze) begin
      // hold the output long enough for the block to back up its input
      fork
        begin
          @(posedge clk_i);
          long_hold = 1'b1;
          repeat (200) @(posedge clk_i);
          long_hold = 1'b0;
        end
      join_none
    end
    queue_random(count / 2);
    // pause the sender until the block has emptied
    drain();
    queue_random(count - count / 2);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    write_flip(1'b0);

    add_sprite(16'h0000, 16'h0000, 16'h0000, 1'b0);  // empty slot
    add_sprite(16'h1000, 16'h0123, 16'h0010, 1'b1);  // flash, odd frame
    add_sprite(16'h1000, 16'h0123, 16'h0010, 1'b0);  // flash, even frame
    add_sprite(16'h0020, 16'h0055, 16'h0140, 1'b0);  // x wraps and drops
    add_sprite(16'h0020, 16'h0055, 16'h01ef, 1'b0);  // last dropped x
    add_sprite(16'h0020, 16'h0055, 16'h01f0, 1'b0);  // x lands on the right edge
    add_sprite(16'h0000, 16'h0001, 16'h01ff, 1'b1);
    add_sprite(16'h00ff, 16'h0002, 16'h013f, 1'b0);
    add_sprite(16'h0100, 16'h0003, 16'h0000, 1'b0);
    add_sprite(16'h01ff, 16'h0004, 16'h3e00, 1'b0);  // colour 31
    add_sprite(16'h0280, 16'h1235, 16'h0050, 1'b0);  // two tall
    add_sprite(16'h4480, 16'h1237, 16'h0050, 1'b0);  // four tall, flip y
    add_sprite(16'h2680, 16'hffff, 16'h0080, 1'b0);  // eight tall, top codes
    add_sprite(16'h6601, 16'h0001, 16'h2090, 1'b1);  // eight tall, base clears to 0
    add_sprite(16'h8800, 16'h0777, 16'hc0a0, 1'b0);  // ignored bits set
    drain();
    write_flip(1'b1);
    add_sprite(16'h0000, 16'h0001, 16'h0000, 1'b0);
    add_sprite(16'h01ff, 16'h0002, 16'h01f0, 1'b0);
    add_sprite(16'h2680, 16'hfff0, 16'h3fff, 1'b0);
    add_sprite(16'h4400, 16'h0008, 16'h013f, 1'b0);
    add_sprite(16'h7e55, 16'h8001, 16'hffff, 1'b0);
    add_sprite(16'h1000, 16'h0009, 16'h0100, 1'b1);
    add_sprite(16'h0100, 16'h0000, 16'h0100, 1'b0);

    run_phase(1'b1, 0, 0, 72, 1'b0);
    run_phase(1'b0, 57, 0, 72, 1'b0);
    run_phase(1'b1, 0, 57, 72, 1'b1);
    run_phase(1'b0, 21, 21, 72, 1'b0);

    drain();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb_sprite_attribute_tile_emitter_unit passed");
    end else begin
      $display("tb_sprite_attribute_tile_emitter_unit failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_sprite_attribute_tile_emitter_unit failed");
    $finish;
  end

endmodule
